// File: design/dpac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpac_pkg;

  // field widths
  localparam int ANGLE_W = 24;
  localparam int DT_W    = 16;
  localparam int GAIN_W  = 24;
  localparam int SKIP_W  = 8;
  localparam int DRIVE_W = 32;
  localparam int ERR_W   = 25;
  localparam int INTEG_W = 48;
  localparam int PROD_W  = 48;
  localparam int DMAG_W  = 25;
  localparam int QUO_W   = DMAG_W + DT_W;
  localparam int PART_W  = PROD_W + 4;
  localparam int TERM_W  = PART_W + 1;
  localparam int ACC_W   = 56;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_SAME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_FLIP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT   = 3'd4;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd0;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd2560000;
  localparam logic [GAIN_W-1:0] DERIV_SAME_RST = 24'd3072;
  localparam logic [GAIN_W-1:0] DERIV_FLIP_RST = 24'd768;
  localparam logic [SKIP_W-1:0] SKIP_COUNT_RST = 8'd10;

  // one quotient bit per divider step
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // weighted terms, accumulated in this order
  localparam int TSEL_W = 2;
  localparam logic [TSEL_W-1:0] TERM_PROP  = 2'd0;
  localparam logic [TSEL_W-1:0] TERM_INTEG = 2'd1;
  localparam logic [TSEL_W-1:0] TERM_DERIV = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain_same_sign;
    logic [GAIN_W-1:0] deriv_gain_sign_flip;
  } dpac_gains_t;

  typedef struct packed {
    logic              load;
    logic              calc_err;
    logic              mul_int;
    logic              add_int;
    logic              div_step;
    logic              mul_hi;
    logic              mul_lo;
    logic              acc;
    logic              sat;
    logic [TSEL_W-1:0] term;
  } dpac_cmd_t;

endpackage

`default_nettype wire

// File: design/dpac_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// input tick channel
interface dpac_tick_if;
  import dpac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic        [DT_W-1:0]    time_step;
  modport source (output valid, output angle, output time_step, input ready);
  modport sink   (input valid, input angle, input time_step, output ready);
endinterface

// result channel
interface dpac_drive_if;
  import dpac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_velocity;
  modport source (output valid, output drive_velocity, input ready);
  modport sink   (input valid, input drive_velocity, output ready);
endinterface

`default_nettype wire

// File: design/dpac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dpac_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  input  wire logic [dpac_pkg::SKIP_W-1:0]  skip_count,
  output dpac_pkg::dpac_cmd_t               cmd
);
  import dpac_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_MINT = 4'd2;
  localparam logic [3:0] S_AINT = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MHI  = 4'd5;
  localparam logic [3:0] S_MLO  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_SAT  = 4'd8;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [3:0]           state, state_next;
  logic [SKIP_W-1:0]    tick_count, tick_count_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [TSEL_W-1:0]    term, term_next;
  logic                 accept;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    tick_count_next = tick_count;
    div_cnt_next    = div_cnt;
    term_next       = term;
    cmd             = '0;
    cmd.term        = term;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (tick_count < skip_count) begin
            tick_count_next = tick_count + 1'b1;
          end else begin
            tick_count_next = '0;
            state_next      = S_ERR;
          end
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = S_MINT;
      end
      S_MINT: begin
        cmd.mul_int = 1'b1;
        state_next  = S_AINT;
      end
      S_AINT: begin
        cmd.add_int  = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          term_next  = TERM_PROP;
          state_next = S_MHI;
        end
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (term == TERM_DERIV) begin
          state_next = S_SAT;
        end else begin
          term_next  = term + 1'b1;
          state_next = S_MHI;
        end
      end
      S_SAT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.sat    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      div_cnt    <= '0;
      term       <= TERM_PROP;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      tick_count <= tick_count_next;
      div_cnt    <= div_cnt_next;
      term       <= term_next;
      if (cmd.sat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/dpac_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dpac_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dpac_pkg::dpac_cmd_t                 cmd,
  input  wire logic signed [dpac_pkg::ANGLE_W-1:0] in_angle,
  input  wire logic        [dpac_pkg::DT_W-1:0]    in_time_step,
  input  wire dpac_pkg::dpac_gains_t               gains,
  output logic signed      [dpac_pkg::DRIVE_W-1:0] drive_velocity
);
  import dpac_pkg::*;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // persistent controller state
  logic                      zero_taken;
  logic signed [ANGLE_W-1:0] zero_angle;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [INTEG_W-1:0] integral;

  // per-update working registers
  logic signed [ANGLE_W-1:0] angle_q;
  logic        [DT_W-1:0]    dt_q;
  logic signed [ERR_W-1:0]   err_q;
  logic        [GAIN_W-1:0]  kd_q;
  logic        [DMAG_W-1:0]  dmag;
  logic                      dneg;
  logic        [DT_W-1:0]    rem;
  logic        [QUO_W-1:0]   quo;
  logic        [PROD_W-1:0]  prod;
  logic        [PART_W-1:0]  part;
  logic signed [ACC_W-1:0]   acc;

  // error magnitude and sign
  logic                      eneg;
  logic        [ERR_W-1:0]   eabs;
  logic        [ANGLE_W-1:0] emag;
  assign eneg = err_q[ERR_W-1];
  assign eabs = eneg ? ERR_W'(-err_q) : err_q;
  assign emag = eabs[ANGLE_W-1:0];

  // error from the reference, first update takes the reference
  logic signed [ANGLE_W-1:0] ref_angle;
  logic signed [ERR_W-1:0]   err_calc;
  assign ref_angle = zero_taken ? zero_angle : angle_q;
  assign err_calc  = ERR_W'(angle_q) - ERR_W'(ref_angle);

  // error change and derivative gain choice
  logic signed [ERR_W:0]  diff;
  logic        [ERR_W:0]  diff_abs;
  logic                   err_pos, prev_pos, prev_neg, sign_flip;
  assign diff      = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_error);
  assign diff_abs  = diff[ERR_W] ? (ERR_W+1)'(-diff) : diff;
  assign err_pos   = !err_q[ERR_W-1] && (err_q != '0);
  assign prev_neg  = prev_error[ERR_W-1];
  assign prev_pos  = !prev_error[ERR_W-1] && (prev_error != '0);
  assign sign_flip = (eneg && prev_pos) || (err_pos && prev_neg);

  // saturating integral update
  logic [ANGLE_W-1:0]      inc;
  logic signed [INTEG_W:0] inc_s, isum;
  assign inc   = prod[DT_W +: ANGLE_W];
  assign inc_s = eneg ? -(INTEG_W+1)'(inc) : (INTEG_W+1)'(inc);
  assign isum  = (INTEG_W+1)'(integral) + inc_s;

  // restoring divide step
  logic [DT_W:0] rem_sh;
  logic          q_bit;
  assign rem_sh = {rem, quo[QUO_W-1]};
  assign q_bit  = (rem_sh >= (DT_W+1)'(dt_q));

  // operand of the current weighted term
  logic [INTEG_W-1:0] imag;
  logic [PROD_W-1:0]  xmag;
  logic               xneg;
  logic [GAIN_W-1:0]  gain_sel;
  assign imag = integral[INTEG_W-1] ? INTEG_W'(-integral) : integral;

  always_comb begin
    case (cmd.term)
      TERM_PROP: begin
        xmag     = PROD_W'(emag);
        xneg     = eneg;
        gain_sel = gains.prop_gain;
      end
      TERM_INTEG: begin
        xmag     = PROD_W'(imag);
        xneg     = integral[INTEG_W-1];
        gain_sel = gains.integ_gain;
      end
      TERM_DERIV: begin
        // zero time step gives no derivative
        xmag     = (dt_q == '0) ? '0 : PROD_W'(quo);
        xneg     = dneg;
        gain_sel = kd_q;
      end
      default: begin
        xmag     = '0;
        xneg     = 1'b0;
        gain_sel = '0;
      end
    endcase
  end

  logic [GAIN_W-1:0] x_hi, x_lo;
  assign x_hi = xmag[PROD_W-1:GAIN_W];
  assign x_lo = xmag[GAIN_W-1:0];

  logic [TERM_W-1:0] term_mag;
  assign term_mag = TERM_W'(part) + TERM_W'(prod[PROD_W-1:20]);

  // negate and clamp the sum
  logic signed [ACC_W-1:0] neg_acc;
  logic                    fits;
  assign neg_acc = -acc;
  assign fits    = (neg_acc[ACC_W-1:DRIVE_W-1] == '0) || (&neg_acc[ACC_W-1:DRIVE_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_taken <= 1'b0;
      prev_error <= '0;
      integral   <= '0;
    end else begin
      if (cmd.calc_err && !zero_taken) begin
        zero_taken <= 1'b1;
      end
      if (cmd.mul_int) begin
        prev_error <= err_q;
      end
      if (cmd.add_int) begin
        if (isum[INTEG_W] != isum[INTEG_W-1]) begin
          integral <= isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
          integral <= isum[INTEG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_q <= in_angle;
      dt_q    <= in_time_step;
    end
    if (cmd.calc_err) begin
      if (!zero_taken) begin
        zero_angle <= angle_q;
      end
      err_q <= err_calc;
      acc   <= '0;
    end
    if (cmd.mul_int) begin
      prod <= PROD_W'(emag) * PROD_W'(dt_q);
      kd_q <= sign_flip ? gains.deriv_gain_sign_flip : gains.deriv_gain_same_sign;
      dmag <= diff_abs[DMAG_W-1:0];
      dneg <= diff[ERR_W];
    end
    if (cmd.add_int) begin
      rem <= '0;
      quo <= {dmag, {DT_W{1'b0}}};
    end
    if (cmd.div_step) begin
      rem <= q_bit ? DT_W'(rem_sh - (DT_W+1)'(dt_q)) : rem_sh[DT_W-1:0];
      quo <= {quo[QUO_W-2:0], q_bit};
    end
    if (cmd.mul_hi) begin
      prod <= PROD_W'(gain_sel) * PROD_W'(x_hi);
    end
    if (cmd.mul_lo) begin
      part <= {prod, 4'b0000};
      prod <= PROD_W'(gain_sel) * PROD_W'(x_lo);
    end
    if (cmd.acc) begin
      acc <= xneg ? acc - ACC_W'(term_mag) : acc + ACC_W'(term_mag);
    end
    if (cmd.sat) begin
      if (fits) begin
        drive_velocity <= neg_acc[DRIVE_W-1:0];
      end else begin
        drive_velocity <= neg_acc[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/decimated_pid_angle_controller_core.sv
// acting tick: error, integral, divider and weighted-term steps run in turn, and the
//   result is loaded once the result register is free; the next tick follows the load
// ignored ticks: one transfer per cycle, no result
// the 41-step restoring divider for the derivative sets the update time
// synchronous active-high reset restores the register defaults and clears the
//   tick count, the zero reference, the previous error and the integral
`timescale 1ns / 1ps
`default_nettype none

module decimated_pid_angle_controller_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  dpac_tick_if.sink                                 tick,
  dpac_drive_if.source                              drive,
  input  wire logic                                 wr_en,
  input  wire logic [dpac_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [dpac_pkg::CFG_DATA_W-1:0]      wr_data
);
  import dpac_pkg::*;

  // configuration registers
  dpac_gains_t       gains;
  logic [SKIP_W-1:0] skip_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain            <= PROP_GAIN_RST;
      gains.integ_gain           <= INTEG_GAIN_RST;
      gains.deriv_gain_same_sign <= DERIV_SAME_RST;
      gains.deriv_gain_sign_flip <= DERIV_FLIP_RST;
      skip_count                 <= SKIP_COUNT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PROP_GAIN:  gains.prop_gain            <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN: gains.integ_gain           <= wr_data[GAIN_W-1:0];
        REG_DERIV_SAME: gains.deriv_gain_same_sign <= wr_data[GAIN_W-1:0];
        REG_DERIV_FLIP: gains.deriv_gain_sign_flip <= wr_data[GAIN_W-1:0];
        REG_SKIP_COUNT: skip_count                 <= wr_data[SKIP_W-1:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // sequencer: decimation, step order, divider count, result valid
  dpac_cmd_t cmd;

  dpac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tick.valid),
    .in_ready   (tick.ready),
    .out_valid  (drive.valid),
    .out_ready  (drive.ready),
    .skip_count (skip_count),
    .cmd        (cmd)
  );

  // arithmetic: error, integral, divider, shared multiplier, result register
  dpac_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_angle       (tick.angle),
    .in_time_step   (tick.time_step),
    .gains          (gains),
    .drive_velocity (drive.drive_velocity)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.sat |-> (!drive.valid || drive.ready))
    else $error("result register loaded while a result is pending");

  // a new result only appears after the saturation step
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(drive.valid) |-> $past(cmd.sat))
    else $error("result valid without a saturation step");

  // the sequencer issues at most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.calc_err, cmd.mul_int, cmd.add_int, cmd.div_step,
              cmd.mul_hi, cmd.mul_lo, cmd.acc, cmd.sat}))
    else $error("more than one datapath step in a cycle");

  // input is only taken while no update is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.acc) |-> !tick.ready)
    else $error("input ready during an update");

endmodule

`default_nettype wire
